>>> design/pcse_pkg.sv
// Shared types, constants and fixed-point helpers for the cubic spline evaluator.
`timescale 1ns / 1ps

package pcse_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SEG_AW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int COEF_DEPTH   = 4 * MAX_SEGMENTS;
  localparam int COEF_AW      = SEG_AW + 2;

  localparam int CMD_W   = 2;
  localparam int SEGF_W  = 4;
  localparam int TERM_W  = 2;
  localparam int CNT_W   = 5;
  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;
  localparam int P_W     = 2 * Q_W;
  localparam int ACC_W   = Q_W + 4;

  localparam int CALC_STEPS = 11;
  localparam int STEP_W     = $clog2(CALC_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_KNOT = 2'd0,
    CMD_WR_COEF = 2'd1,
    CMD_EVAL    = 2'd2
  } cmd_code_t;

  typedef enum logic [TERM_W-1:0] {
    TERM_C3 = 2'd0,
    TERM_C2 = 2'd1,
    TERM_C1 = 2'd2,
    TERM_C0 = 2'd3
  } term_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_CALC,
    ST_LOAD_OUT
  } state_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MO_TT,
    MO_TC3,
    MO_T2T,
    MO_TC2,
    MO_TC1,
    MO_T2C3,
    MO_T2C2,
    MO_T3C3
  } mul_op_t;

  // where the rounded product goes, and with which small multiple
  typedef enum logic [2:0] {
    QD_NONE,
    QD_T2,
    QD_T3,
    QD_POS,
    QD_VEL2,
    QD_VEL3,
    QD_ACC6
  } q_dst_t;

  typedef struct packed {
    logic               knot_we;
    logic               coef_we;
    logic               t_ld;
    logic [SEG_AW-1:0]  knot_raddr;
    logic [COEF_AW-1:0] coef_raddr;
    logic               coef_ld;
    term_t              coef_term;
    mul_op_t            mul_op;
    q_dst_t             q_dst;
    logic               pos_init;
    logic               vel_init;
    logic               acc_init;
    logic               out_ld;
    logic               out_found;
  } pcse_cmd_t;

  typedef struct packed {
    logic knot_gt;
    logic out_free;
  } pcse_sts_t;

  localparam logic signed [P_W-1:0] Q_HALF = P_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [P_W-1:0] P_QMAX =
    {{(P_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [P_W-1:0] P_QMIN =
    {{(P_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] A_QMAX =
    {{(ACC_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] A_QMIN =
    {{(ACC_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  // round half up to Q16.16, then clamp to 32 bits
  function automatic logic signed [Q_W-1:0] round_prod(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] r;
    logic signed [P_W-1:0] s;
    r = p + Q_HALF;
    s = r >>> FRAC_W;
    if (s > P_QMAX) begin
      return P_QMAX[Q_W-1:0];
    end else if (s < P_QMIN) begin
      return P_QMIN[Q_W-1:0];
    end
    return s[Q_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    if (v > A_QMAX) begin
      return A_QMAX[Q_W-1:0];
    end else if (v < A_QMIN) begin
      return A_QMIN[Q_W-1:0];
    end
    return v[Q_W-1:0];
  endfunction

endpackage

>>> design/pcse_if.sv
// Valid/ready channel interfaces for spline commands and spline results.
`timescale 1ns / 1ps

interface pcse_in_if import pcse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [SEGF_W-1:0]        segment;
  logic [TERM_W-1:0]        term;
  logic signed [Q_W-1:0]    table_value;
  logic signed [Q_W-1:0]    eval_time;

  modport source (output valid, cmd, segment, term, table_value, eval_time, input ready);
  modport sink   (input valid, cmd, segment, term, table_value, eval_time, output ready);
endinterface

interface pcse_out_if import pcse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [Q_W-1:0]    position;
  logic signed [Q_W-1:0]    velocity;
  logic signed [Q_W-1:0]    acceleration;
  logic                     found;

  modport source (output valid, position, velocity, acceleration, found, input ready);
  modport sink   (input valid, position, velocity, acceleration, found, output ready);
endinterface

>>> design/pcse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pcse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/pcse_ctrl.sv
// Controller: accepts beats, scans knots, sequences the shared multiplier.
`timescale 1ns / 1ps

module pcse_ctrl import pcse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SEGF_W-1:0] in_segment,
  input  pcse_sts_t         sts,
  output pcse_cmd_t         cmd
);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SEG_AW-1:0]   idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    seg_count_r;
  logic                accept;
  logic                seg_ok;
  logic                scan_last;
  term_t               rd_term;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign seg_ok    = int'(in_segment) < MAX_SEGMENTS;
  assign scan_last = (int'(idx_r) + 1 >= int'(seg_count_r)) ||
                     (int'(idx_r) + 1 >= MAX_SEGMENTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      seg_count_r <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        seg_count_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    rd_term   = TERM_C3;
    cmd       = '0;
    cmd.knot_raddr = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_code_t'(in_cmd))
            CMD_WR_KNOT: cmd.knot_we = seg_ok;
            CMD_WR_COEF: cmd.coef_we = seg_ok;
            CMD_EVAL: begin
              cmd.t_ld  = 1'b1;
              idx_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = (seg_count_r == '0) ? ST_LOAD_OUT : ST_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.knot_gt) begin
          found_nxt = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_CALC;
        end else if (scan_last) begin
          state_nxt = ST_LOAD_OUT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_CALC: begin
        // a product issued at one step is registered in p_r, then rounded into q_r, where a later step's q_dst takes it
        unique case (int'(step_r))
          0: begin
            rd_term    = TERM_C3;
            cmd.mul_op = MO_TT;
          end
          1: begin
            rd_term       = TERM_C2;
            cmd.coef_ld   = 1'b1;
            cmd.coef_term = TERM_C3;
          end
          2: begin
            rd_term       = TERM_C1;
            cmd.coef_ld   = 1'b1;
            cmd.coef_term = TERM_C2;
            cmd.mul_op    = MO_TC3;
            cmd.q_dst     = QD_T2;
          end
          3: begin
            rd_term       = TERM_C0;
            cmd.coef_ld   = 1'b1;
            cmd.coef_term = TERM_C1;
            cmd.mul_op    = MO_T2T;
            cmd.acc_init  = 1'b1;
          end
          4: begin
            cmd.coef_ld   = 1'b1;
            cmd.coef_term = TERM_C0;
            cmd.mul_op    = MO_TC2;
            cmd.q_dst     = QD_ACC6;
            cmd.vel_init  = 1'b1;
          end
          5: begin
            cmd.mul_op   = MO_TC1;
            cmd.q_dst    = QD_T3;
            cmd.pos_init = 1'b1;
          end
          6: begin
            cmd.mul_op = MO_T2C3;
            cmd.q_dst  = QD_VEL2;
          end
          7: begin
            cmd.mul_op = MO_T2C2;
            cmd.q_dst  = QD_POS;
          end
          8: begin
            cmd.mul_op = MO_T3C3;
            cmd.q_dst  = QD_VEL3;
          end
          9:  cmd.q_dst = QD_POS;
          10: cmd.q_dst = QD_POS;
          default: ;
        endcase
        if (int'(step_r) == CALC_STEPS - 1) begin
          state_nxt = ST_LOAD_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_LOAD_OUT: begin
        cmd.out_found = found_r;
        // hold until the result register can take the beat
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    cmd.coef_raddr = {idx_r, rd_term};
  end

  a_out_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded while result register busy");

  a_calc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && int'(step_r) == CALC_STEPS - 1) |=> state_r == ST_LOAD_OUT)
    else $error("compute sequence did not end in result load");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.knot_we || cmd.coef_we || cmd.t_ld) |-> (state_r == ST_IDLE && in_valid))
    else $error("table write or time load without an accepted beat");

  a_found_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN_CMP && sts.knot_gt) |=> (state_r == ST_CALC && step_r == '0))
    else $error("matching knot did not start the compute sequence");

endmodule

>>> design/pcse_dp.sv
// Datapath: knot and coefficient memories, shared multiplier, accumulators, result register.
`timescale 1ns / 1ps

module pcse_dp import pcse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcse_cmd_t             cmd,
  output pcse_sts_t             sts,
  input  logic [SEGF_W-1:0]     in_segment,
  input  logic [TERM_W-1:0]     in_term,
  input  logic signed [Q_W-1:0] in_table_value,
  input  logic signed [Q_W-1:0] in_eval_time,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [Q_W-1:0] out_position,
  output logic signed [Q_W-1:0] out_velocity,
  output logic signed [Q_W-1:0] out_acceleration,
  output logic                  out_found
);

  logic signed [Q_W-1:0]   knot_rd;
  logic signed [Q_W-1:0]   coef_rd;
  logic [SEG_AW-1:0]       wr_seg;

  logic signed [Q_W-1:0]   t_r, t2_r, t3_r;
  logic signed [Q_W-1:0]   c3_r, c2_r, c1_r, c0_r;
  logic signed [Q_W-1:0]   mul_a, mul_b;
  logic signed [P_W-1:0]   p_r;
  logic signed [Q_W-1:0]   q_r;
  logic signed [ACC_W-1:0] q_ext;
  logic signed [ACC_W-1:0] pos_r, pos_nxt;
  logic signed [ACC_W-1:0] vel_r, vel_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic                    out_valid_r;
  logic signed [Q_W-1:0]   out_pos_r, out_vel_r, out_acc_r;
  logic                    out_found_r;

  assign wr_seg = SEG_AW'(in_segment);

  pcse_ram #(.WIDTH(Q_W), .DEPTH(MAX_SEGMENTS)) u_knot_ram (
    .clk   (clk),
    .we    (cmd.knot_we),
    .waddr (wr_seg),
    .wdata (in_table_value),
    .raddr (cmd.knot_raddr),
    .rdata (knot_rd)
  );

  pcse_ram #(.WIDTH(Q_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_we),
    .waddr ({wr_seg, in_term}),
    .wdata (in_table_value),
    .raddr (cmd.coef_raddr),
    .rdata (coef_rd)
  );

  assign sts.knot_gt  = knot_rd > t_r;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.mul_op)
      MO_TT:   begin mul_a = t_r;  mul_b = t_r;  end
      MO_TC3:  begin mul_a = t_r;  mul_b = c3_r; end
      MO_T2T:  begin mul_a = t2_r; mul_b = t_r;  end
      MO_TC2:  begin mul_a = t_r;  mul_b = c2_r; end
      MO_TC1:  begin mul_a = t_r;  mul_b = c1_r; end
      MO_T2C3: begin mul_a = t2_r; mul_b = c3_r; end
      MO_T2C2: begin mul_a = t2_r; mul_b = c2_r; end
      MO_T3C3: begin mul_a = t3_r; mul_b = c3_r; end
      default: begin mul_a = t_r;  mul_b = t_r;  end
    endcase
  end

  assign q_ext = ACC_W'(q_r);

  always_comb begin
    pos_nxt = cmd.pos_init ? ACC_W'(c0_r) : pos_r;
    vel_nxt = cmd.vel_init ? ACC_W'(c1_r) : vel_r;
    acc_nxt = cmd.acc_init ? (ACC_W'(c2_r) <<< 1) : acc_r;
    unique case (cmd.q_dst)
      QD_POS:  pos_nxt = pos_r + q_ext;
      QD_VEL2: vel_nxt = vel_r + (q_ext <<< 1);
      QD_VEL3: vel_nxt = vel_r + (q_ext <<< 1) + q_ext;
      QD_ACC6: acc_nxt = acc_r + (q_ext <<< 2) + (q_ext <<< 1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r   <= P_W'(mul_a) * P_W'(mul_b);
    q_r   <= round_prod(p_r);
    pos_r <= pos_nxt;
    vel_r <= vel_nxt;
    acc_r <= acc_nxt;
    if (cmd.t_ld) begin
      t_r <= in_eval_time;
    end
    if (cmd.q_dst == QD_T2) begin
      t2_r <= q_r;
    end
    if (cmd.q_dst == QD_T3) begin
      t3_r <= q_r;
    end
    if (cmd.coef_ld) begin
      case (cmd.coef_term)
        TERM_C3: c3_r <= coef_rd;
        TERM_C2: c2_r <= coef_rd;
        TERM_C1: c1_r <= coef_rd;
        TERM_C0: c0_r <= coef_rd;
        default: ;
      endcase
    end
    if (cmd.out_ld) begin
      out_found_r <= cmd.out_found;
      out_pos_r   <= cmd.out_found ? sat_acc(pos_r) : '0;
      out_vel_r   <= cmd.out_found ? sat_acc(vel_r) : '0;
      out_acc_r   <= cmd.out_found ? sat_acc(acc_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_acceleration = out_acc_r;
  assign out_found        = out_found_r;

endmodule

>>> design/piecewise_cubic_spline_eval.sv
// Top level of the piecewise cubic spline evaluator.
// Load beats write the knot or coefficient table as they are accepted. An evaluate
// beat scans the knots with a memory read and a compare per segment and, on a knot
// past its time, runs the 11-step sequence of the one shared multiplier. Input is
// taken again the cycle after the result is loaded. Reset: idle, segment_count 1,
// tables keep old contents.
`timescale 1ns / 1ps

module piecewise_cubic_spline_eval import pcse_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  pcse_in_if.sink          in_ch,
  pcse_out_if.source       out_ch
);

  pcse_cmd_t cmd;
  pcse_sts_t sts;

  pcse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_ch.cmd),
    .in_segment (in_ch.segment),
    .sts        (sts),
    .cmd        (cmd)
  );

  pcse_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_segment       (in_ch.segment),
    .in_term          (in_ch.term),
    .in_table_value   (in_ch.table_value),
    .in_eval_time     (in_ch.eval_time),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_position     (out_ch.position),
    .out_velocity     (out_ch.velocity),
    .out_acceleration (out_ch.acceleration),
    .out_found        (out_ch.found)
  );

endmodule
